// File: sv/cbc_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge bank controller package
// Shared widths, address region codes, configuration indexes and the
// structures passed between the controller modules.
// ----------------------------------------------------------------------------
package cbc_pkg;

  localparam int unsigned AddrW     = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned RomOffW   = 23;
  localparam int unsigned RamOffW   = 17;
  localparam int unsigned RamSizeW  = 18;
  localparam int unsigned RomBankW  = 9;
  localparam int unsigned RamBankW  = 4;
  localparam int unsigned RomShift  = 14;  // 0x4000 bytes per ROM bank
  localparam int unsigned RamShift  = 13;  // 0x2000 bytes per RAM bank
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [3:0]          RamEnKey     = 4'hA;
  localparam logic [RamSizeW-1:0] RamSizeReset = 18'd32768;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CTRL_TYPE = 1'b0,
    CFG_RAM_SIZE  = 1'b1
  } cfg_idx_e;

  // Controller rule sets.
  typedef enum logic {
    CTRL_GEN1 = 1'b0,
    CTRL_GEN2 = 1'b1
  } ctrl_type_e;

  // 8 KiB regions selected by address bits 15:13.
  typedef enum logic [2:0] {
    RGN_RAM_EN  = 3'd0,  // 0x0000-0x1FFF
    RGN_ROM_LO  = 3'd1,  // 0x2000-0x3FFF
    RGN_BANK_HI = 3'd2,  // 0x4000-0x5FFF
    RGN_MODE    = 3'd3,  // 0x6000-0x7FFF
    RGN_HIGH4   = 3'd4,
    RGN_HIGH5   = 3'd5,
    RGN_HIGH6   = 3'd6,
    RGN_HIGH7   = 3'd7
  } region_e;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } wr_req_t;

  typedef struct packed {
    ctrl_type_e          ctrl_type;
    logic [RamSizeW-1:0] ram_size;
  } cfg_t;

endpackage

// File: sv/cbc_wr_if.sv
// ----------------------------------------------------------------------------
// CPU write channel
// Valid/ready channel carrying one cartridge register write request.
// ----------------------------------------------------------------------------
interface cbc_wr_if;
  logic                       valid;
  logic                       ready;
  logic [cbc_pkg::AddrW-1:0]  write_address;
  logic [cbc_pkg::DataW-1:0]  write_data;

  modport source (output valid, output write_address, output write_data, input ready);
  modport sink   (input valid, input write_address, input write_data, output ready);
endinterface

// File: sv/cbc_bank_if.sv
// ----------------------------------------------------------------------------
// Bank status channel
// Valid/ready channel carrying the bank offsets after each write request.
// ----------------------------------------------------------------------------
interface cbc_bank_if;
  logic                        valid;
  logic                        ready;
  logic [cbc_pkg::RomOffW-1:0] rom_bank_offset;
  logic [cbc_pkg::RamOffW-1:0] ram_bank_offset;
  logic                        ram_enabled;

  modport source (output valid, output rom_bank_offset, output ram_bank_offset,
                  output ram_enabled, input ready);
  modport sink   (input valid, input rom_bank_offset, input ram_bank_offset,
                  input ram_enabled, output ready);
endinterface

// File: sv/cbc_bank_regs.sv
// ----------------------------------------------------------------------------
// Bank register file
// Holds both controllers' bank registers and applies one registered write
// request per enabled cycle. The current bank state is the result itself.
// ----------------------------------------------------------------------------
module cbc_bank_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  cbc_pkg::wr_req_t               req_i,
  input  cbc_pkg::cfg_t                  cfg_i,
  output logic [cbc_pkg::RomBankW-1:0]   rom_bank_o,
  output logic [cbc_pkg::RamBankW-1:0]   ram_bank_o,
  output logic                           ram_en_o
);

  logic [cbc_pkg::RomBankW-1:0] rom_bank_q, rom_bank_d;
  logic [cbc_pkg::RamBankW-1:0] ram_bank_q, ram_bank_d;
  logic                         ram_en_q, ram_en_d;
  logic [6:0]                   g1_sel_q, g1_sel_d;
  logic                         g1_mode_q, g1_mode_d;
  logic [7:0]                   g2_low_q, g2_low_d;
  logic                         g2_high_q, g2_high_d;

  cbc_pkg::region_e             region;
  logic [4:0]                   low5;
  logic [cbc_pkg::RamOffW-1:0]  ram_off_try;
  logic                         ram_sel_ok;

  assign region = cbc_pkg::region_e'(req_i.addr[15:13]);
  // Bank zero in the low five bits maps to bank one.
  assign low5 = (req_i.data[4:0] == 5'd0) ? 5'd1 : req_i.data[4:0];

  assign ram_off_try = {req_i.data[3:0], {cbc_pkg::RamShift{1'b0}}};
  assign ram_sel_ok  = (req_i.data[7:4] == 4'd0) &&
                       ({1'b0, ram_off_try} < cfg_i.ram_size);

  always_comb begin
    rom_bank_d = rom_bank_q;
    ram_bank_d = ram_bank_q;
    ram_en_d   = ram_en_q;
    g1_sel_d   = g1_sel_q;
    g1_mode_d  = g1_mode_q;
    g2_low_d   = g2_low_q;
    g2_high_d  = g2_high_q;
    unique case (region)
      cbc_pkg::RGN_RAM_EN: begin
        ram_en_d = (req_i.data[3:0] == cbc_pkg::RamEnKey);
      end
      cbc_pkg::RGN_ROM_LO: begin
        if (cfg_i.ctrl_type == cbc_pkg::CTRL_GEN1) begin
          g1_sel_d   = {g1_sel_q[6:5], low5};
          rom_bank_d = {2'b00, g1_sel_q[6:5], low5};
        end else if (!req_i.addr[12]) begin
          g2_low_d   = req_i.data;
          rom_bank_d = {g2_high_q, req_i.data};
        end else begin
          g2_high_d  = req_i.data[0];
          rom_bank_d = {req_i.data[0], g2_low_q};
        end
      end
      cbc_pkg::RGN_BANK_HI: begin
        if (cfg_i.ctrl_type == cbc_pkg::CTRL_GEN1 && !g1_mode_q) begin
          g1_sel_d   = {req_i.data[1:0], g1_sel_q[4:0]};
          rom_bank_d = {2'b00, req_i.data[1:0], g1_sel_q[4:0]};
        end else if (ram_sel_ok) begin
          ram_bank_d = req_i.data[3:0];
        end
      end
      cbc_pkg::RGN_MODE: begin
        // Only the first-generation controller has a banking mode. Entering
        // mode one drops the high bank bits without touching the ROM offset.
        if (cfg_i.ctrl_type == cbc_pkg::CTRL_GEN1) begin
          g1_mode_d = req_i.data[0];
          if (req_i.data[0]) begin
            g1_sel_d = {2'b00, g1_sel_q[4:0]};
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_bank_q <= cbc_pkg::RomBankW'(1);
      ram_bank_q <= '0;
      ram_en_q   <= 1'b0;
      g1_sel_q   <= 7'd1;
      g1_mode_q  <= 1'b0;
      g2_low_q   <= 8'd1;
      g2_high_q  <= 1'b0;
    end else if (wr_en_i) begin
      rom_bank_q <= rom_bank_d;
      ram_bank_q <= ram_bank_d;
      ram_en_q   <= ram_en_d;
      g1_sel_q   <= g1_sel_d;
      g1_mode_q  <= g1_mode_d;
      g2_low_q   <= g2_low_d;
      g2_high_q  <= g2_high_d;
    end
  end

  assign rom_bank_o = rom_bank_q;
  assign ram_bank_o = ram_bank_q;
  assign ram_en_o   = ram_en_q;

  a_g1_low_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g1_sel_q[4:0] != 5'd0)
    else $error("first-generation low bank bits are zero");

  a_mode1_no_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g1_mode_q |-> (g1_sel_q[6:5] == 2'b00))
    else $error("high bank bits set in banking mode one");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_en_i |=> ($stable(rom_bank_q) && $stable(ram_bank_q) && $stable(ram_en_q)))
    else $error("bank state changed without a write request");

endmodule

// File: sv/cartridge_bank_controller_top.sv
// ----------------------------------------------------------------------------
// Cartridge bank controller
// Two-stage valid/ready wrapper around the bank register file.
// ----------------------------------------------------------------------------
// Each write request is captured in an input register and then applied to the
// bank registers once the response slot is free; the bank registers present
// the ROM bank offset, RAM bank offset and RAM enable as the response. One
// request is taken every cycle while the response side keeps up. Configuration
// writes are expected only while no request is in flight.

module cartridge_bank_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cbc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cbc_pkg::RamSizeW-1:0]  cfg_wdata_i,
  cbc_wr_if.sink                        wr_i,
  cbc_bank_if.source                    bank_o
);

  cbc_pkg::cfg_t                 cfg_q;
  cbc_pkg::wr_req_t              req_q;
  logic                          req_vld_q;
  logic                          out_vld_q;
  logic                          stage_en;
  logic [cbc_pkg::RomBankW-1:0]  rom_bank;
  logic [cbc_pkg::RamBankW-1:0]  ram_bank;
  logic                          ram_en;

  // The bank registers double as the response register, so both stages move
  // together whenever the response slot is free.
  assign stage_en   = !out_vld_q || bank_o.ready;
  assign wr_i.ready = stage_en || !req_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ctrl_type <= cbc_pkg::CTRL_GEN1;
      cfg_q.ram_size  <= cbc_pkg::RamSizeReset;
    end else if (cfg_we_i) begin
      unique case (cbc_pkg::cfg_idx_e'(cfg_idx_i))
        cbc_pkg::CFG_CTRL_TYPE: cfg_q.ctrl_type <= cbc_pkg::ctrl_type_e'(cfg_wdata_i[0]);
        cbc_pkg::CFG_RAM_SIZE:  cfg_q.ram_size  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (wr_i.ready) begin
        req_vld_q <= wr_i.valid;
      end
      if (stage_en) begin
        out_vld_q <= req_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.ready && wr_i.valid) begin
      req_q.addr <= wr_i.write_address;
      req_q.data <= wr_i.write_data;
    end
  end

  cbc_bank_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (stage_en && req_vld_q),
    .req_i      (req_q),
    .cfg_i      (cfg_q),
    .rom_bank_o (rom_bank),
    .ram_bank_o (ram_bank),
    .ram_en_o   (ram_en)
  );

  assign bank_o.valid           = out_vld_q;
  assign bank_o.rom_bank_offset = {rom_bank, {cbc_pkg::RomShift{1'b0}}};
  assign bank_o.ram_bank_offset = {ram_bank, {cbc_pkg::RamShift{1'b0}}};
  assign bank_o.ram_enabled     = ram_en;

  a_req_to_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_vld_q && stage_en) |=> out_vld_q)
    else $error("request in input stage did not reach the response");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_vld_q |-> wr_i.ready)
    else $error("empty input stage refused a request");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !bank_o.ready && req_vld_q) |=> (req_vld_q && $stable(req_q)))
    else $error("input stage changed during a response stall");

endmodule

// File: sim/cartridge_bank_controller_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cartridge bank controller testbench
// Drives CPU write requests through the valid/ready channel, predicts the
// bank offsets and RAM enable for every request, and checks each response
// field by field. It covers both rule sets and a range of RAM sizes, idles
// the write channel at random and back-pressures the response channel.
// ----------------------------------------------------------------------------

module cartridge_bank_controller_top_tb;
  import cbc_pkg::*;

  typedef struct {
    logic [RomOffW-1:0] rom;
    logic [RamOffW-1:0] ram;
    logic               en;
  } bank_state_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [RamSizeW-1:0] cfg_wdata_i;

  cbc_wr_if   wr_if();
  cbc_bank_if bank_if();

  cartridge_bank_controller_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .wr_i        (wr_if),
    .bank_o      (bank_if)
  );

  always #5 clk_i = ~clk_i;

  // Predicted controller state.
  ctrl_type_e          cfg_kind;
  logic [RamSizeW-1:0] cfg_ram_bytes;
  logic                ram_on;
  logic [RomOffW-1:0]  rom_off;
  logic [RamOffW-1:0]  ram_off;
  logic [6:0]          g1_bank;
  logic                g1_mode;
  logic [7:0]          g2_lo;
  logic                g2_hi;

  bank_state_t pending_banks[$];
  int unsigned mismatches = 0;

  bit src_idle_en  = 1'b1;
  bit sink_idle_en = 1'b1;
  bit hold_go      = 1'b0;
  bit hold_seen    = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;

  function automatic void select_ram(input logic [7:0] d);
    logic [RamSizeW-1:0] offs;
    if (d <= 8'd15) begin
      offs = {1'b0, d[3:0], 13'd0};
      if (offs < cfg_ram_bytes) ram_off = offs[RamOffW-1:0];
    end
  endfunction

  // Applies one CPU write to the predicted state and queues the response.
  function automatic void apply_bank_write(input logic [AddrW-1:0] a,
                                           input logic [DataW-1:0] d);
    region_e     rgn;
    bank_state_t resp;
    rgn = region_e'(a[15:13]);
    if (rgn == RGN_RAM_EN) begin
      ram_on = (d[3:0] == RamEnKey);
    end else if (cfg_kind == CTRL_GEN1) begin
      case (rgn)
        RGN_ROM_LO: begin
          g1_bank[4:0] = (d[4:0] == 5'd0) ? 5'd1 : d[4:0];
          rom_off = {2'b00, g1_bank, 14'd0};
        end
        RGN_BANK_HI: begin
          if (!g1_mode) begin
            g1_bank[6:5] = d[1:0];
            rom_off = {2'b00, g1_bank, 14'd0};
          end else begin
            select_ram(d);
          end
        end
        RGN_MODE: begin
          g1_mode = d[0];
          if (g1_mode) g1_bank[6:5] = 2'b00;
        end
        default: ;
      endcase
    end else begin
      case (rgn)
        RGN_ROM_LO: begin
          // Bit 12 splits this region into the low byte and bit 8 of the bank.
          if (!a[12]) g2_lo = d;
          else g2_hi = d[0];
          rom_off = {g2_hi, g2_lo, 14'd0};
        end
        RGN_BANK_HI: select_ram(d);
        default: ;
      endcase
    end
    resp.rom = rom_off;
    resp.ram = ram_off;
    resp.en  = ram_on;
    pending_banks.push_back(resp);
  endfunction

  function automatic void report_field(input string name, input logic [31:0] got,
                                       input logic [31:0] want);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
  endfunction

  // Response checker.
  always @(posedge clk_i) begin : check_resp
    bank_state_t want;
    if (rst_ni && bank_if.valid && bank_if.ready) begin
      if (pending_banks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: response with no request outstanding", $time);
      end else begin
        want = pending_banks.pop_front();
        if (bank_if.rom_bank_offset !== want.rom)
          report_field("rom_bank_offset", 32'(bank_if.rom_bank_offset), 32'(want.rom));
        if (bank_if.ram_bank_offset !== want.ram)
          report_field("ram_bank_offset", 32'(bank_if.ram_bank_offset), 32'(want.ram));
        if (bank_if.ram_enabled !== want.en)
          report_field("ram_enabled", 32'(bank_if.ram_enabled), 32'(want.en));
      end
    end
  end

  // Response side ready: one long hold on request, then short random stalls.
  always @(negedge clk_i) begin
    if (hold_go && !hold_seen) begin
      hold_seen = 1'b1;
      hold_left = 40;
    end
    if (!rst_ni) begin
      bank_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      bank_if.ready <= 1'b0;
      hold_left--;
    end else if (stall_left > 0) begin
      bank_if.ready <= 1'b0;
      stall_left--;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      bank_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      bank_if.ready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high so back-to-back requests need no gap.
  task automatic send_write(input logic [AddrW-1:0] a, input logic [DataW-1:0] d);
    int unsigned gap;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      wr_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    wr_if.valid         <= 1'b1;
    wr_if.write_address <= a;
    wr_if.write_data    <= d;
    @(posedge clk_i);
    while (!wr_if.ready) @(posedge clk_i);
    apply_bank_write(a, d);
    @(negedge clk_i);
  endtask

  task automatic drain();
    wr_if.valid <= 1'b0;
    while (pending_banks.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [RamSizeW-1:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_CTRL_TYPE) cfg_kind = ctrl_type_e'(val[0]);
    else cfg_ram_bytes = val;
  endtask

  task automatic set_idling(input bit on);
    @(posedge clk_i);
    src_idle_en  = on;
    sink_idle_en = on;
    @(negedge clk_i);
  endtask

  task automatic test_ram_enable();
    send_write(16'h0000, 8'h0A);
    send_write(16'h1FFF, 8'h1A);
    send_write(16'h0123, 8'h0B);
    send_write(16'h1000, 8'hFA);
    send_write(16'h0000, 8'h00);
    send_write(16'h1FFF, 8'hFF);
  endtask

  task automatic test_gen1_rom_bank();
    send_write(16'h2000, 8'h00);  // bank zero maps to one
    send_write(16'h3FFF, 8'hFF);
    send_write(16'h2ABC, 8'hE0);  // low five bits zero, upper bits ignored
    send_write(16'h4000, 8'h03);
    send_write(16'h5FFF, 8'hFE);
    send_write(16'h4123, 8'hFC);
  endtask

  task automatic test_gen1_ram_bank();
    send_write(16'h4000, 8'h02);
    send_write(16'h6000, 8'h01);  // mode 1 clears the high bank bits
    send_write(16'h4000, 8'h03);
    send_write(16'h4000, 8'h04);  // beyond a 32 KiB RAM
    send_write(16'h5FFF, 8'h10);
    send_write(16'h4000, 8'h00);
    send_write(16'h7FFF, 8'hFE);
    send_write(16'h2000, 8'h05);
  endtask

  task automatic test_high_addr();
    send_write(16'h8000, 8'hFF);
    send_write(16'hFFFF, 8'h00);
    send_write(16'hA000, 8'h0A);
  endtask

  task automatic test_gen2();
    write_cfg(CFG_CTRL_TYPE, RamSizeW'(CTRL_GEN2));
    send_write(16'h8000, 8'h00);  // switching type changes no output by itself
    send_write(16'h2000, 8'h00);  // bank zero is kept as is
    send_write(16'h2FFF, 8'hFF);
    send_write(16'h3000, 8'h01);
    send_write(16'h3FFF, 8'hFE);
    send_write(16'h4000, 8'h0F);
    send_write(16'h6000, 8'hFF);
    write_cfg(CFG_RAM_SIZE, 18'd131072);
    send_write(16'h5FFF, 8'h0F);
    write_cfg(CFG_RAM_SIZE, 18'd0);
    send_write(16'h4000, 8'h00);  // no bank fits an empty RAM
    write_cfg(CFG_RAM_SIZE, 18'h3FFFF);
    send_write(16'h4000, 8'h0E);
    write_cfg(CFG_CTRL_TYPE, RamSizeW'(CTRL_GEN1));
    send_write(16'h4000, 8'h01);
  endtask

  task automatic send_random_write();
    logic [AddrW-1:0] a;
    logic [DataW-1:0] d;
    int unsigned pick;
    a = AddrW'($urandom_range(0, 16'hFFFF));
    d = DataW'($urandom_range(0, 8'hFF));
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      a[15:13] = RGN_RAM_EN;
      if ($urandom_range(0, 1)) d[3:0] = RamEnKey;
    end else if (pick < 45) begin
      a[15:13] = RGN_ROM_LO;
    end else if (pick < 72) begin
      a[15:13] = RGN_BANK_HI;
      if ($urandom_range(0, 1)) d = DataW'($urandom_range(0, 16));
    end else if (pick < 87) begin
      a[15:13] = RGN_MODE;
    end
    send_write(a, d);
  endtask

  // The response side holds off for a long stretch while requests keep coming.
  task automatic test_pressure();
    hold_go = 1'b1;
    repeat (30) send_random_write();
  endtask

  task automatic test_random();
    logic [RamSizeW-1:0] sizes[6];
    sizes = '{18'd0, 18'd8192, 18'd32768, 18'd131072, 18'h3FFFF, 18'd0};
    for (int p = 0; p < 6; p++) begin
      if (p == 5) begin
        sizes[p] = RamSizeW'($urandom_range(0, 18'h3FFFF));
        drain();
        set_idling(1'b0);
      end
      write_cfg(CFG_CTRL_TYPE, RamSizeW'(p[0]));
      write_cfg(CFG_RAM_SIZE, sizes[p]);
      repeat (300) send_random_write();
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_CTRL_TYPE;
    cfg_wdata_i         = '0;
    wr_if.valid         = 1'b0;
    wr_if.write_address = '0;
    wr_if.write_data    = '0;
    cfg_kind      = CTRL_GEN1;
    cfg_ram_bytes = RamSizeReset;
    ram_on        = 1'b0;
    rom_off       = 23'h4000;
    ram_off       = '0;
    g1_bank       = 7'd1;
    g1_mode       = 1'b0;
    g2_lo         = 8'd1;
    g2_hi         = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_ram_enable();
    test_gen1_rom_bank();
    test_gen1_ram_bank();
    test_high_addr();
    test_gen2();
    test_pressure();
    test_random();

    drain();
    repeat (6) @(posedge clk_i);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
